[src/dbl_pkg.sv]
// Package for the depth buffer linearizer.
// Holds field widths, register indexes and the tag type; no dependencies.
package dbl_pkg;
    localparam int WORD_W = 32;
    localparam int NUM_W = 96;
    localparam int DEN_W = 64;
    localparam int CFG_IDX_W = 8;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_CLIP_NEAR = 8'd0;
    localparam cfg_idx_t REG_CLIP_FAR = 8'd1;

    typedef struct packed {
        logic valid;
        logic err;
    } dbl_tag_t;
endpackage

[src/dbl_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on dbl_pkg; the user must keep the quotient within one word, the block itself does not enforce it.
module dbl_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  dbl_pkg::dbl_tag_t           in_tag,
    input  logic [dbl_pkg::NUM_W-1:0]   num,
    input  logic [dbl_pkg::DEN_W-1:0]   den,
    output dbl_pkg::dbl_tag_t           out_tag,
    output logic [dbl_pkg::WORD_W-1:0]  quotient
);
    import dbl_pkg::*;

    localparam int STEPS = WORD_W;

    dbl_tag_t          tag_reg [0:STEPS];
    logic [DEN_W-1:0]  rem_reg [0:STEPS];
    logic [DEN_W-1:0]  den_reg [0:STEPS];
    logic [WORD_W-1:0] low_reg [0:STEPS];
    logic [WORD_W-1:0] q_reg   [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                tag_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= in_tag;
            for (int k = 1; k <= STEPS; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num[NUM_W-1:WORD_W];
            low_reg[0] <= num[WORD_W-1:0];
            den_reg[0] <= den;
            q_reg[0] <= '0;
            for (int k = 1; k <= STEPS; k++)
            begin
                logic [DEN_W:0] trial;
                logic [DEN_W:0] diff;
                trial = {rem_reg[k-1], low_reg[k-1][WORD_W-1]};
                diff = trial - {1'b0, den_reg[k-1]};
                if (!diff[DEN_W])
                begin
                    rem_reg[k] <= diff[DEN_W-1:0];
                    q_reg[k] <= {q_reg[k-1][WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= trial[DEN_W-1:0];
                    q_reg[k] <= {q_reg[k-1][WORD_W-2:0], 1'b0};
                end
                low_reg[k] <= {low_reg[k-1][WORD_W-2:0], 1'b0};
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign out_tag = tag_reg[STEPS];
    assign quotient = q_reg[STEPS];

    a_tag_moves: assert property (@(posedge clk) disable iff (!rst_n)
        en && tag_reg[STEPS-1].valid |=> tag_reg[STEPS].valid)
        else $error("valid item lost in divider");
    a_tag_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(tag_reg[STEPS]))
        else $error("divider moved while stalled");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg[STEPS].valid && !tag_reg[STEPS].err |-> rem_reg[STEPS] < den_reg[STEPS])
        else $error("divider remainder out of range");
endmodule

[src/depth_buffer_linearizer.sv]
// Throughput: one item per cycle; the whole pipeline halts while a result waits.
// Stages: input capture, products, numerator and denominator, then 32 one-bit divider steps.
// Reset clears all valid bits and loads near 0.1 and far 100.0 in the plane format.
// Depends on dbl_pkg and dbl_divider.
module depth_buffer_linearizer
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  dbl_pkg::cfg_idx_t             cfg_index,
    input  logic [dbl_pkg::WORD_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dbl_pkg::WORD_W-1:0]    depth_code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dbl_pkg::WORD_W-1:0]    distance,
    output logic                          config_error
);
    import dbl_pkg::*;

    localparam logic [WORD_W-1:0] NEAR_RESET = WORD_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [WORD_W-1:0] FAR_RESET = WORD_W'(64'd100 << FRAC_BITS);

    logic [WORD_W-1:0] near_reg;
    logic [WORD_W-1:0] far_reg;
    logic              en;

    dbl_tag_t              s1_tag_reg;
    logic [WORD_W-1:0]     s1_code_reg;
    logic [WORD_W-1:0]     s1_near_reg;
    logic [WORD_W-1:0]     s1_far_reg;
    dbl_tag_t              s2_tag_reg;
    logic [DEN_W-1:0]      s2_prod_reg;
    logic [DEN_W-1:0]      s2_cprod_reg;
    logic [WORD_W-1:0]     s2_far_reg;
    logic [NUM_W-1:0]      num;
    logic [DEN_W-1:0]      den;
    dbl_tag_t              div_tag;
    logic [WORD_W-1:0]     quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= NEAR_RESET;
            far_reg <= FAR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLIP_NEAR: near_reg <= cfg_wdata;
                REG_CLIP_FAR:  far_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en = out_ready || !out_valid;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else if (en)
        begin
            s1_tag_reg.valid <= in_valid;
            s1_tag_reg.err <= (near_reg == '0) || (far_reg <= near_reg);
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_code_reg <= depth_code;
            s1_near_reg <= near_reg;
            s1_far_reg <= far_reg;
            s2_prod_reg <= DEN_W'(s1_near_reg) * DEN_W'(s1_far_reg);
            s2_cprod_reg <= DEN_W'(s1_code_reg) * DEN_W'(s1_far_reg - s1_near_reg);
            s2_far_reg <= s1_far_reg;
        end
    end

    assign num = {s2_prod_reg, {WORD_W{1'b0}}} - NUM_W'(s2_prod_reg);
    assign den = {s2_far_reg, {WORD_W{1'b0}}} - DEN_W'(s2_far_reg) - s2_cprod_reg;

    dbl_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_tag   (s2_tag_reg),
        .num      (num),
        .den      (den),
        .out_tag  (div_tag),
        .quotient (quotient)
    );

    assign out_valid = div_tag.valid;
    assign config_error = div_tag.err;
    assign distance = div_tag.err ? '0 : quotient;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && config_error |-> distance == '0)
        else $error("error result carries a distance");
    a_accept_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_tag_reg.valid)
        else $error("accepted item not captured");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance))
        else $error("result changed while stalled");
endmodule
